>>> rtl/onf_pkg.sv
package onf_pkg;

    typedef enum logic [2:0] {
        ST_DOWN     = 3'd0,
        ST_ATTEMPT  = 3'd1,
        ST_INIT     = 3'd2,
        ST_TWOWAY   = 3'd3,
        ST_EXSTART  = 3'd4,
        ST_EXCHANGE = 3'd5,
        ST_LOADING  = 3'd6,
        ST_FULL     = 3'd7
    } t_nbr_state;

    typedef enum logic [3:0] {
        EV_HELLO       = 4'd0,
        EV_START       = 4'd1,
        EV_ONEWAY      = 4'd2,
        EV_TWOWAY      = 4'd3,
        EV_NEGDONE     = 4'd4,
        EV_EXCHDONE    = 4'd5,
        EV_BADLSREQ    = 4'd6,
        EV_LOADDONE    = 4'd7,
        EV_ADJOK       = 4'd8,
        EV_SEQMISMATCH = 4'd9,
        EV_KILL        = 4'd10,
        EV_INACTIVITY  = 4'd11,
        EV_LLDOWN      = 4'd12
    } t_event;

    localparam logic [1:0] TMR_NONE    = 2'd0;
    localparam logic [1:0] TMR_START   = 2'd1;
    localparam logic [1:0] TMR_CANCEL  = 2'd2;

    localparam logic [2:0] DD_FLAGS_NONE = 3'd0;
    localparam logic [2:0] DD_FLAGS_IMMS = 3'd7;
    localparam logic [2:0] DD_FLAGS_MORE = 3'd2;

    typedef struct packed {
        logic [3:0]  action;
        logic [30:0] new_seqnum;
        logic        request_list_empty;
        logic        master_flag;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  nbr_state;
        logic [1:0]  inactivity_cmd;
        logic [1:0]  retrans_cmd;
        logic        send_dd;
        logic [2:0]  dd_flags;
        logic [31:0] dd_sequence;
        logic        send_ls_request;
        logic        originate_lsa;
        logic        purge_neighbor;
        logic        event_error;
    } t_out_word;

endpackage

>>> rtl/onf_core.sv
module onf_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  onf_pkg::t_in_word  i_item,
    output onf_pkg::t_out_word o_result
);
    import onf_pkg::*;

    t_nbr_state  r_state;
    t_nbr_state  n_state;
    logic [31:0] r_seq;
    logic [31:0] n_seq;
    logic [31:0] seq_inc;
    t_out_word   res;

    assign seq_inc = r_seq + 32'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_DOWN;
            r_seq   <= '0;
        end else if (i_fire) begin
            r_state <= n_state;
            r_seq   <= n_seq;
        end
    end

    always_comb begin
        n_state = r_state;
        n_seq   = r_seq;
        res     = '0;
        unique case (t_event'(i_item.action))
            EV_HELLO: begin
                if (r_state == ST_DOWN || r_state == ST_ATTEMPT) begin
                    n_state = ST_INIT;
                end
                res.inactivity_cmd = TMR_START;
            end
            EV_START: begin
                if (r_state == ST_DOWN) begin
                    n_state = ST_ATTEMPT;
                end
                res.inactivity_cmd = TMR_START;
            end
            EV_ONEWAY: begin
                if (r_state >= ST_TWOWAY) begin
                    n_state = ST_INIT;
                end
            end
            EV_TWOWAY, EV_BADLSREQ, EV_ADJOK, EV_SEQMISMATCH: begin
                // Each of these enters ExStart from its own set of states.
                if ((i_item.action == EV_TWOWAY && r_state == ST_INIT) ||
                    (i_item.action == EV_BADLSREQ && r_state >= ST_EXCHANGE) ||
                    (i_item.action == EV_ADJOK && r_state == ST_TWOWAY) ||
                    (i_item.action == EV_SEQMISMATCH)) begin
                    n_state         = ST_EXSTART;
                    n_seq           = seq_inc;
                    res.send_dd     = 1'b1;
                    res.dd_flags    = DD_FLAGS_IMMS;
                    res.dd_sequence = seq_inc;
                    res.retrans_cmd = TMR_START;
                end
            end
            EV_NEGDONE: begin
                if (r_state != ST_EXSTART) begin
                    res.event_error = 1'b1;
                end else begin
                    n_state = ST_EXCHANGE;
                    if (i_item.master_flag) begin
                        res.send_dd     = 1'b1;
                        res.dd_flags    = DD_FLAGS_MORE;
                        res.dd_sequence = r_seq;
                        res.retrans_cmd = TMR_START;
                    end
                end
            end
            EV_EXCHDONE: begin
                if (i_item.request_list_empty) begin
                    n_state           = ST_FULL;
                    res.originate_lsa = 1'b1;
                    res.retrans_cmd   = TMR_CANCEL;
                end else begin
                    n_state             = ST_LOADING;
                    res.send_ls_request = 1'b1;
                end
            end
            EV_LOADDONE: begin
                if (r_state == ST_LOADING) begin
                    n_state = ST_FULL;
                end
            end
            EV_KILL, EV_INACTIVITY, EV_LLDOWN: begin
                // Losing a full adjacency through inactivity changes the router LSA; kill and link-down do not.
                if (i_item.action == EV_INACTIVITY && r_state == ST_FULL) begin
                    res.originate_lsa = 1'b1;
                end
                n_state            = ST_DOWN;
                n_seq              = {1'b0, i_item.new_seqnum};
                res.inactivity_cmd = TMR_CANCEL;
                res.purge_neighbor = 1'b1;
            end
            default: begin
            end
        endcase
        res.nbr_state = n_state;
    end

    assign o_result = res;

`ifndef NO_ASSERTIONS
    a_dd_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && !res.send_dd |-> res.dd_flags == DD_FLAGS_NONE && res.dd_sequence == '0)
        else $error("description fields set without a send");

    a_kill_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.action == EV_KILL |=> r_state == ST_DOWN)
        else $error("kill did not bring the neighbour down");

    a_err_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && res.event_error |=> $stable(r_state) && $stable(r_seq))
        else $error("erroneous event changed the neighbour");

    a_seq_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> $stable(r_seq) && $stable(r_state))
        else $error("neighbour changed without an event");
`endif

endmodule

>>> rtl/ospf_neighbor_fsm.sv
// Channel   Signals                             Word
// input     i_in_valid / o_in_ready             i_in_data  (t_in_word)
// output    o_out_valid / i_out_ready           o_out_data (t_out_word)
//
// An event word is registered on acceptance, decoded from the input register and its
// result registered; one word may be accepted every cycle while the output is not stalled.
// The input register advances whenever the result register is empty or being taken.
// Synchronous reset puts the neighbour in Down with a sequence number of zero.
// A stalled output holds the result register; an empty input register still takes one
// word, after which o_in_ready stays low until the result is taken. Nothing is dropped.
module ospf_neighbor_fsm (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  onf_pkg::t_in_word  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output onf_pkg::t_out_word o_out_data
);
    import onf_pkg::*;

    logic      r_in_vld;
    t_in_word  r_in_data;
    logic      r_out_vld;
    t_out_word r_out_data;
    t_out_word result;
    logic      advance;
    logic      in_take;

    assign advance    = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || advance;
    assign in_take    = i_in_valid && o_in_ready;

    onf_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_in_data),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_data <= i_in_data;
        end
        if (advance) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_data;

endmodule

>>> sim/ospf_neighbor_fsm_chk.sv
module ospf_neighbor_fsm_chk (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  onf_pkg::t_in_word  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  onf_pkg::t_out_word i_out_data,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_result_count
);
    import onf_pkg::*;

    // Shadow copy of the neighbour: its state and the DD sequence number.
    t_nbr_state  nbr_st;
    logic [31:0] dd_seq;
    t_out_word   expected_actions[$];
    t_out_word   want;

    function automatic void enter_exstart(inout t_out_word r);
        nbr_st        = ST_EXSTART;
        dd_seq        = dd_seq + 32'd1;
        r.send_dd     = 1'b1;
        r.dd_flags    = DD_FLAGS_IMMS;
        r.dd_sequence = dd_seq;
        r.retrans_cmd = TMR_START;
    endfunction

    function automatic void drop_neighbor(inout t_out_word r, input logic [30:0] fresh_seq);
        nbr_st           = ST_DOWN;
        dd_seq           = {1'b0, fresh_seq};
        r.inactivity_cmd = TMR_CANCEL;
        r.purge_neighbor = 1'b1;
    endfunction

    function automatic t_out_word next_actions(input t_in_word w);
        t_out_word r;
        r = '0;
        case (w.action)
            EV_HELLO: begin
                if (nbr_st == ST_DOWN || nbr_st == ST_ATTEMPT)
                    nbr_st = ST_INIT;
                r.inactivity_cmd = TMR_START;
            end
            EV_START: begin
                if (nbr_st == ST_DOWN)
                    nbr_st = ST_ATTEMPT;
                r.inactivity_cmd = TMR_START;
            end
            EV_ONEWAY: begin
                if (nbr_st >= ST_TWOWAY)
                    nbr_st = ST_INIT;
            end
            EV_TWOWAY: begin
                if (nbr_st == ST_INIT)
                    enter_exstart(r);
            end
            EV_NEGDONE: begin
                if (nbr_st != ST_EXSTART) begin
                    r.event_error = 1'b1;
                end else begin
                    nbr_st = ST_EXCHANGE;
                    if (w.master_flag) begin
                        r.send_dd     = 1'b1;
                        r.dd_flags    = DD_FLAGS_MORE;
                        r.dd_sequence = dd_seq;
                        r.retrans_cmd = TMR_START;
                    end
                end
            end
            EV_EXCHDONE: begin
                if (w.request_list_empty) begin
                    nbr_st          = ST_FULL;
                    r.originate_lsa = 1'b1;
                    r.retrans_cmd   = TMR_CANCEL;
                end else begin
                    nbr_st            = ST_LOADING;
                    r.send_ls_request = 1'b1;
                end
            end
            EV_BADLSREQ: begin
                if (nbr_st >= ST_EXCHANGE)
                    enter_exstart(r);
            end
            EV_LOADDONE: begin
                if (nbr_st == ST_LOADING)
                    nbr_st = ST_FULL;
            end
            EV_ADJOK: begin
                if (nbr_st == ST_TWOWAY)
                    enter_exstart(r);
            end
            EV_SEQMISMATCH: begin
                enter_exstart(r);
            end
            EV_KILL, EV_LLDOWN: begin
                drop_neighbor(r, w.new_seqnum);
            end
            EV_INACTIVITY: begin
                // Losing a full adjacency means the router LSA must be reissued.
                if (nbr_st == ST_FULL)
                    r.originate_lsa = 1'b1;
                drop_neighbor(r, w.new_seqnum);
            end
            default: begin
            end
        endcase
        r.nbr_state = nbr_st;
        return r;
    endfunction

    task automatic cmp_field(input string fname, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
        if (got_v !== exp_v) begin
            o_fail_count++;
            if (o_fail_count <= 10)
                $display("chk: result word %0d field %s expected 0x%0h got 0x%0h",
                         o_result_count, fname, exp_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            nbr_st = ST_DOWN;
            dd_seq = '0;
            expected_actions.delete();
            o_pending = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                o_result_count++;
                if (expected_actions.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("chk: result word %0d arrived with nothing expected: 0x%0h",
                                 o_result_count, i_out_data);
                end else begin
                    want = expected_actions.pop_front();
                    cmp_field("nbr_state", 32'(want.nbr_state),
                              32'(i_out_data.nbr_state));
                    cmp_field("inactivity_cmd", 32'(want.inactivity_cmd),
                              32'(i_out_data.inactivity_cmd));
                    cmp_field("retrans_cmd", 32'(want.retrans_cmd),
                              32'(i_out_data.retrans_cmd));
                    cmp_field("send_dd", 32'(want.send_dd), 32'(i_out_data.send_dd));
                    cmp_field("dd_flags", 32'(want.dd_flags), 32'(i_out_data.dd_flags));
                    cmp_field("dd_sequence", want.dd_sequence, i_out_data.dd_sequence);
                    cmp_field("send_ls_request", 32'(want.send_ls_request),
                              32'(i_out_data.send_ls_request));
                    cmp_field("originate_lsa", 32'(want.originate_lsa),
                              32'(i_out_data.originate_lsa));
                    cmp_field("purge_neighbor", 32'(want.purge_neighbor),
                              32'(i_out_data.purge_neighbor));
                    cmp_field("event_error", 32'(want.event_error),
                              32'(i_out_data.event_error));
                end
            end
            if (i_in_valid && i_in_ready)
                expected_actions.push_back(next_actions(i_in_data));
            o_pending = expected_actions.size();
        end
    end

endmodule

>>> sim/ospf_neighbor_fsm_tb.sv
module ospf_neighbor_fsm_tb;
    import onf_pkg::*;

    // Event codes beyond the defined set; the block must ignore them.
    localparam logic [3:0] EV_UNUSED_LO = 4'd13;
    localparam logic [3:0] EV_UNUSED_HI = 4'd15;

    localparam int RANDOM_EVENTS = 1200;
    localparam int HOLD_CYCLES   = 80;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      ev_valid  = 1'b0;
    logic      ev_ready;
    t_in_word  ev_word   = '0;
    logic      res_valid;
    logic      res_ready = 1'b0;
    t_out_word res_word;

    int fail_count;
    int pending;
    int result_count;
    int events_sent = 0;
    int idle_max    = 6;
    int hold_req    = 0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    ospf_neighbor_fsm dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (ev_valid),
        .o_in_ready  (ev_ready),
        .i_in_data   (ev_word),
        .o_out_valid (res_valid),
        .i_out_ready (res_ready),
        .o_out_data  (res_word)
    );

    ospf_neighbor_fsm_chk chk (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (ev_valid),
        .i_in_ready     (ev_ready),
        .i_in_data      (ev_word),
        .i_out_valid    (res_valid),
        .i_out_ready    (res_ready),
        .i_out_data     (res_word),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    // Entered and left at a falling edge. Valid stays high between back-to-back words.
    task automatic push_event(input logic [3:0] act, input logic [30:0] seq,
                              input logic empty, input logic master);
        int gap;
        gap = $urandom_range(0, idle_max);
        if (gap > 0) begin
            ev_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        ev_valid <= 1'b1;
        ev_word  <= '{action: act, new_seqnum: seq, request_list_empty: empty,
                      master_flag: master};
        do @(posedge clk); while (!ev_ready);
        events_sent++;
        @(negedge clk);
    endtask

    task automatic push_rand(input logic [3:0] act);
        push_event(act, 31'($urandom), 1'($urandom), 1'($urandom));
    endtask

    task automatic drain_pause();
        ev_valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
    endtask

    function automatic logic [3:0] any_event();
        if ($urandom_range(0, 19) == 0)
            return 4'($urandom_range(EV_UNUSED_LO, EV_UNUSED_HI));
        return 4'($urandom_range(EV_HELLO, EV_LLDOWN));
    endfunction

    // A full bring-up from a teardown to Loading or Full, then a few stray events.
    task automatic run_session();
        logic empty;
        int   extra;
        case ($urandom_range(0, 2))
            0: push_rand(EV_KILL);
            1: push_rand(EV_LLDOWN);
            default: push_rand(EV_INACTIVITY);
        endcase
        if ($urandom_range(0, 1))
            push_rand(EV_START);
        push_rand(EV_HELLO);
        push_rand(EV_TWOWAY);
        if ($urandom_range(0, 5) == 0)
            push_rand(EV_SEQMISMATCH);
        push_rand(EV_NEGDONE);
        empty = 1'($urandom);
        push_event(EV_EXCHDONE, 31'($urandom), empty, 1'($urandom));
        if (!empty && $urandom_range(0, 3) != 0)
            push_rand(EV_LOADDONE);
        extra = $urandom_range(0, 4);
        repeat (extra)
            push_rand(any_event());
    endtask

    // The receiver draws a stall per word, or serves a long hold-off when one is asked for.
    initial begin
        int stall;
        wait (rst_n === 1'b1);
        forever begin
            if (hold_req > 0) begin
                res_ready <= 1'b0;
                repeat (hold_req) @(negedge clk);
                hold_req = 0;
            end else begin
                stall = $urandom_range(0, idle_max);
                if (stall > 0) begin
                    res_ready <= 1'b0;
                    repeat (stall) @(negedge clk);
                end
            end
            res_ready <= 1'b1;
            do @(posedge clk); while (!res_valid);
            @(negedge clk);
        end
    end

    initial begin
        bit hold_done;
        bit drain_done;
        int random_start;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        push_event(EV_KILL,        '1, 1'b1, 1'b1);
        push_event(EV_ONEWAY,      '0, 1'b0, 1'b0);
        push_event(EV_ADJOK,       '0, 1'b0, 1'b0);
        push_event(EV_BADLSREQ,    '0, 1'b0, 1'b0);
        push_event(EV_LOADDONE,    '0, 1'b0, 1'b0);
        push_event(EV_NEGDONE,     '0, 1'b1, 1'b1);
        push_event(EV_START,       '0, 1'b0, 1'b0);
        push_event(EV_START,       '1, 1'b1, 1'b1);
        push_event(EV_HELLO,       '0, 1'b0, 1'b0);
        push_event(EV_ONEWAY,      '0, 1'b0, 1'b0);
        push_event(EV_TWOWAY,      '0, 1'b0, 1'b0);
        push_event(EV_ADJOK,       '0, 1'b0, 1'b0);
        push_event(EV_NEGDONE,     '0, 1'b0, 1'b1);
        push_event(EV_NEGDONE,     '0, 1'b0, 1'b1);
        push_event(EV_EXCHDONE,    '0, 1'b0, 1'b0);
        push_event(EV_LOADDONE,    '0, 1'b0, 1'b0);
        push_event(EV_INACTIVITY,  '0, 1'b0, 1'b0);
        push_event(EV_SEQMISMATCH, '1, 1'b1, 1'b1);
        push_event(EV_NEGDONE,     '1, 1'b1, 1'b0);
        push_event(EV_BADLSREQ,    '0, 1'b0, 1'b0);
        push_event(EV_EXCHDONE,    '0, 1'b1, 1'b0);
        push_event(EV_ONEWAY,      '0, 1'b0, 1'b0);
        push_event(EV_UNUSED_LO,   '1, 1'b1, 1'b1);
        push_event(EV_UNUSED_HI,   '1, 1'b1, 1'b1);
        push_event(EV_LLDOWN,      31'h2AAA_AAAA, 1'b0, 1'b0);
        drain_pause();

        random_start = events_sent;
        while (events_sent - random_start < RANDOM_EVENTS) begin
            // Two stretches run with no random idling on either side; the first also asks for the long output hold-off.
            if ((events_sent - random_start >= 400 && events_sent - random_start < 460) ||
                (events_sent - random_start >= 700 && events_sent - random_start < 800))
                idle_max = 0;
            else
                idle_max = 6;
            if (!hold_done && events_sent - random_start >= 400) begin
                hold_req  = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (!drain_done && events_sent - random_start >= 900) begin
                drain_pause();
                drain_done = 1'b1;
            end
            if ($urandom_range(0, 9) < 7)
                run_session();
            else
                push_event(any_event(), 31'($urandom), 1'($urandom), 1'($urandom));
        end
        ev_valid <= 1'b0;

        wait (pending == 0);
        repeat (8) @(negedge clk);
        $display("ospf_neighbor_fsm_tb: %0d event words sent, %0d results checked,",
                 events_sent, result_count);
        $display("ospf_neighbor_fsm_tb: with random stalls, a long output hold-off and a drain.");
        if (fail_count == 0)
            $display("ospf_neighbor_fsm_tb: done, clean");
        else
            $display("ospf_neighbor_fsm_tb: done, errors");
        $finish;
    end

    initial begin
        #400000;
        $display("ospf_neighbor_fsm_tb: timed out with %0d words outstanding", pending);
        $display("ospf_neighbor_fsm_tb: done, errors");
        $finish;
    end

endmodule

>>> filelist.f
rtl/onf_pkg.sv
rtl/onf_core.sv
rtl/ospf_neighbor_fsm.sv
sim/ospf_neighbor_fsm_chk.sv
sim/ospf_neighbor_fsm_tb.sv
